// ===== sv/fps_pkg.sv =====
package fps_pkg;

  localparam int IN_BITS = 320;
  localparam int OUT_BITS = 96;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_EDGE  = 2'd1,
    KIND_GOAL  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    XOP_ORIENT = 3'd0,
    XOP_NL_LP  = 3'd1,
    XOP_NL_RP  = 3'd2,
    XOP_NR_RP  = 3'd3,
    XOP_NR_LP  = 3'd4
  } xop_t;

  typedef struct packed {
    logic latch_in;
    logic wr_start;
    logic wr_portal;
    logic wr_goal;
    logic clr_req;
    logic set_ovf;
    logic x_start;
    xop_t x_op;
    logic fun_init;
    logic rd;
    logic take_l;
    logic take_r;
    logic restart_l;
    logic restart_r;
    logic i_inc;
    logic emit_cur;
    logic emit_goal;
    logic flush;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  cnt_zero;
    logic  cnt_full;
    logic  x_done;
    logic  x_pos;
    logic  x_neg;
    logic  i_in_range;
    logic  emit_ok;
    logic  out_free;
    logic  goal_differs;
  } sts_t;

endpackage

// ===== sv/funnel_path_smoother.sv =====
// Start and unknown items only pass through decode; an edge below the portal cap also waits for the cross product unit.
// Goal after at least one portal: funnel pass over the portal visits plus restarts, paced by the
// shared cross product unit (two to four tests per visit).
// Output waits stall the pass.
// Input is held off until the current item or funnel pass is done.
// Synchronous active-high reset clears control and counts; portal memories are not cleared.
module funnel_path_smoother #(
  parameter int MAX_PORTALS = 64,
  parameter int COORD_BITS  = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, from_x, from_z, to_x, to_z
  input  logic [319:0] s_tdata,
  // kind
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // point_x, point_y, point_z
  output logic [95:0]  m_tdata,
  // overflow
  output logic         m_tuser,
  output logic         m_tlast
);

  fps_pkg::cmd_t cmd;
  fps_pkg::sts_t sts;

  fps_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .cmd(cmd), .sts(sts)
  );

  fps_datapath #(.MAX_PORTALS(MAX_PORTALS), .COORD_BITS(COORD_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_kind(s_tuser), .in_data(s_tdata),
    .m_tready(m_tready), .m_tvalid(m_tvalid), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

endmodule

// ===== sv/fps_ram.sv =====
module fps_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/fps_cross.sv =====
module fps_cross #(
  parameter int W = 33
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [W-1:0] ux,
  input  logic signed [W-1:0] uz,
  input  logic signed [W-1:0] vx,
  input  logic signed [W-1:0] vz,
  output logic                done,
  output logic                pos,
  output logic                neg
);

  logic signed [W-1:0]   su, sz, tx, tz;
  logic signed [2*W-1:0] p1, p2;
  logic signed [2*W:0]   diff;
  logic [2:0]            ph;

  assign diff = (2*W+1)'(p1) - (2*W+1)'(p2);

  always_ff @(posedge clk) begin
    if (rst) begin
      ph   <= '0;
      done <= 1'b0;
    end else begin
      ph   <= {ph[1:0], start};
      done <= ph[2];
    end
    if (start) begin
      su <= ux;
      sz <= uz;
      tx <= vx;
      tz <= vz;
    end
    if (ph[0]) p1 <= su * tz;
    if (ph[1]) p2 <= sz * tx;
    if (ph[2]) begin
      pos <= !diff[2*W] && (diff != '0);
      neg <= diff[2*W];
    end
  end

endmodule

// ===== sv/fps_datapath.sv =====
module fps_datapath #(
  parameter int MAX_PORTALS = 64,
  parameter int COORD_BITS  = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  fps_pkg::cmd_t               cmd,
  output fps_pkg::sts_t               sts,
  input  logic [1:0]                  in_kind,
  input  logic [fps_pkg::IN_BITS-1:0] in_data,
  input  logic                        m_tready,
  output logic                        m_tvalid,
  output logic [fps_pkg::OUT_BITS-1:0] m_tdata,
  output logic                        m_tuser,
  output logic                        m_tlast
);

  localparam int CB = COORD_BITS;
  localparam int PW = 3 * CB;
  localparam int XW = CB + 1;
  localparam int IW = $clog2(MAX_PORTALS + 1);
  localparam int AW = $clog2(MAX_PORTALS);

  logic [1:0]    kind;
  logic [PW-1:0] a_p, b_p, start_p, cur, lp, rp, pend;
  logic [CB-1:0] from_x, from_z, to_x, to_z;
  logic [IW-1:0] cnt, i, li, ri, npts;
  logic          ovf, pend_valid;
  logic [PW-1:0] nl, nr;
  logic [PW-1:0] wl, wr;
  logic          we;
  logic [AW-1:0] waddr;
  logic signed [XW-1:0] ux, uz, vx, vz;
  logic          x_done, x_pos, x_neg;
  logic          out_free;

  function automatic logic signed [XW-1:0] dif(logic [CB-1:0] p, logic [CB-1:0] q);
    return XW'(signed'(p)) - XW'(signed'(q));
  endfunction

  function automatic logic [CB-1:0] px(logic [PW-1:0] p);
    return p[PW-1 -: CB];
  endfunction

  function automatic logic [CB-1:0] pz(logic [PW-1:0] p);
    return p[CB-1:0];
  endfunction

  function automatic logic [31:0] ext(logic [CB-1:0] v);
    return 32'(signed'(v));
  endfunction

  always_comb begin
    we    = cmd.wr_start | cmd.wr_portal | cmd.wr_goal;
    waddr = cmd.wr_start ? '0 : AW'(cnt + IW'(1));
    wl    = a_p;
    wr    = a_p;
    if (cmd.wr_portal && !x_pos) begin
      wl = b_p;
      wr = a_p;
    end else if (cmd.wr_portal) begin
      wl = a_p;
      wr = b_p;
    end
  end

  fps_ram #(.WIDTH(PW), .DEPTH(MAX_PORTALS)) u_left (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wl),
    .re(cmd.rd), .raddr(i[AW-1:0]), .rdata(nl)
  );

  fps_ram #(.WIDTH(PW), .DEPTH(MAX_PORTALS)) u_right (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wr),
    .re(cmd.rd), .raddr(i[AW-1:0]), .rdata(nr)
  );

  always_comb begin
    ux = dif(px(nl), px(cur));
    uz = dif(pz(nl), pz(cur));
    vx = dif(px(lp), px(cur));
    vz = dif(pz(lp), pz(cur));
    case (cmd.x_op)
      fps_pkg::XOP_ORIENT: begin
        ux = dif(px(b_p), px(a_p));
        uz = dif(pz(b_p), pz(a_p));
        vx = dif(to_x, from_x);
        vz = dif(to_z, from_z);
      end
      fps_pkg::XOP_NL_RP: begin
        vx = dif(px(rp), px(cur));
        vz = dif(pz(rp), pz(cur));
      end
      fps_pkg::XOP_NR_RP: begin
        ux = dif(px(nr), px(cur));
        uz = dif(pz(nr), pz(cur));
        vx = dif(px(rp), px(cur));
        vz = dif(pz(rp), pz(cur));
      end
      fps_pkg::XOP_NR_LP: begin
        ux = dif(px(nr), px(cur));
        uz = dif(pz(nr), pz(cur));
      end
      default: ;
    endcase
  end

  fps_cross #(.W(XW)) u_cross (
    .clk(clk), .rst(rst), .start(cmd.x_start),
    .ux(ux), .uz(uz), .vx(vx), .vz(vz),
    .done(x_done), .pos(x_pos), .neg(x_neg)
  );

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      ovf        <= 1'b0;
      pend_valid <= 1'b0;
      npts       <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (((cmd.emit_cur || cmd.emit_goal) && pend_valid && npts != IW'(MAX_PORTALS))
          || cmd.flush) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd.clr_req) begin
        cnt <= '0;
        ovf <= 1'b0;
      end
      if (cmd.wr_portal) cnt <= cnt + IW'(1);
      if (cmd.set_ovf) ovf <= 1'b1;
      if (cmd.fun_init) begin
        pend_valid <= 1'b0;
        npts       <= '0;
      end
      if ((cmd.emit_cur || cmd.emit_goal) && npts != IW'(MAX_PORTALS)) begin
        pend_valid <= 1'b1;
        npts       <= npts + IW'(1);
      end
      if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      kind   <= in_kind;
      a_p    <= {in_data[CB-1:0], in_data[32+CB-1:32], in_data[64+CB-1:64]};
      b_p    <= {in_data[96+CB-1:96], in_data[128+CB-1:128], in_data[160+CB-1:160]};
      from_x <= in_data[192+CB-1:192];
      from_z <= in_data[224+CB-1:224];
      to_x   <= in_data[256+CB-1:256];
      to_z   <= in_data[288+CB-1:288];
    end
    if (cmd.wr_start) start_p <= a_p;
    if (cmd.fun_init) begin
      cur <= start_p;
      lp  <= start_p;
      rp  <= start_p;
      li  <= '0;
      ri  <= '0;
      i   <= IW'(1);
    end
    if (cmd.take_l) begin
      lp <= nl;
      li <= i;
    end
    if (cmd.take_r) begin
      rp <= nr;
      ri <= i;
    end
    if (cmd.restart_r) begin
      cur <= rp;
      lp  <= rp;
      li  <= ri;
      i   <= ri + IW'(1);
    end
    if (cmd.restart_l) begin
      cur <= lp;
      rp  <= lp;
      ri  <= li;
      i   <= li + IW'(1);
    end
    if (cmd.i_inc) i <= i + IW'(1);
    if ((cmd.emit_cur || cmd.emit_goal) && npts != IW'(MAX_PORTALS)) begin
      pend <= cmd.emit_goal ? a_p : cur;
      if (pend_valid) begin
        m_tdata <= {ext(pz(pend)), ext(pend[2*CB-1:CB]), ext(px(pend))};
        m_tuser <= ovf;
        m_tlast <= 1'b0;
      end
    end
    if (cmd.flush) begin
      m_tdata <= {ext(pz(pend)), ext(pend[2*CB-1:CB]), ext(px(pend))};
      m_tuser <= ovf;
      m_tlast <= 1'b1;
    end
  end

  always_comb begin
    sts.kind         = fps_pkg::kind_t'(kind);
    sts.cnt_zero     = (cnt == '0);
    sts.cnt_full     = (cnt >= IW'(MAX_PORTALS - 2));
    sts.x_done       = x_done;
    sts.x_pos        = x_pos;
    sts.x_neg        = x_neg;
    sts.i_in_range   = (i <= cnt + IW'(1));
    sts.emit_ok      = out_free || !pend_valid || (npts == IW'(MAX_PORTALS));
    sts.out_free     = out_free;
    sts.goal_differs = (cur != a_p);
  end

`ifndef SYNTH
  a_npts_cap: assert property (@(posedge clk) disable iff (rst)
    npts <= IW'(MAX_PORTALS)) else $error("point count beyond cap");
  a_flush_pend: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |-> pend_valid && out_free) else $error("flush without pending point");
  a_rd_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |-> i < IW'(MAX_PORTALS)) else $error("read index out of range");
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_cur || cmd.emit_goal) && pend_valid && npts != IW'(MAX_PORTALS)
    |-> out_free) else $error("push into busy output");
`endif

endmodule

// ===== sv/fps_ctrl.sv =====
module fps_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output fps_pkg::cmd_t cmd,
  input  fps_pkg::sts_t sts
);

  typedef enum logic [18:0] {
    S_IDLE  = 19'h00001,
    S_DEC   = 19'h00002,
    S_OWAIT = 19'h00004,
    S_EMIT  = 19'h00008,
    S_LOOP  = 19'h00010,
    S_RD    = 19'h00020,
    S_X1    = 19'h00040,
    S_W1    = 19'h00080,
    S_X2    = 19'h00100,
    S_W2    = 19'h00200,
    S_X3    = 19'h00400,
    S_W3    = 19'h00800,
    S_X4    = 19'h01000,
    S_W4    = 19'h02000,
    S_NEXT  = 19'h04000,
    S_FIN   = 19'h08000,
    S_GEMIT = 19'h10000,
    S_FLUSH = 19'h20000,
    S_SPARE = 19'h40000
  } state_t;

  state_t state, state_next;

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.x_op   = fps_pkg::XOP_ORIENT;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_DEC;
        end
      end
      S_DEC: begin
        state_next = S_IDLE;
        unique case (sts.kind)
          fps_pkg::KIND_START: begin
            cmd.wr_start = 1'b1;
            cmd.clr_req  = 1'b1;
          end
          fps_pkg::KIND_EDGE: begin
            if (sts.cnt_full) begin
              cmd.set_ovf = 1'b1;
            end else begin
              cmd.x_start = 1'b1;
              state_next  = S_OWAIT;
            end
          end
          fps_pkg::KIND_GOAL: begin
            if (sts.cnt_zero) begin
              cmd.clr_req = 1'b1;
            end else begin
              cmd.wr_goal  = 1'b1;
              cmd.fun_init = 1'b1;
              state_next   = S_EMIT;
            end
          end
          default: ;
        endcase
      end
      S_OWAIT: begin
        if (sts.x_done) begin
          cmd.wr_portal = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_EMIT: begin
        if (sts.emit_ok) begin
          cmd.emit_cur = 1'b1;
          state_next   = S_LOOP;
        end
      end
      S_LOOP: state_next = sts.i_in_range ? S_RD : S_FIN;
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_X1;
      end
      S_X1: begin
        cmd.x_start = 1'b1;
        cmd.x_op    = fps_pkg::XOP_NL_LP;
        state_next  = S_W1;
      end
      S_W1: begin
        if (sts.x_done) state_next = sts.x_neg ? S_X3 : S_X2;
      end
      S_X2: begin
        cmd.x_start = 1'b1;
        cmd.x_op    = fps_pkg::XOP_NL_RP;
        state_next  = S_W2;
      end
      S_W2: begin
        if (sts.x_done) begin
          if (sts.x_pos) begin
            cmd.restart_r = 1'b1;
            state_next    = S_EMIT;
          end else begin
            cmd.take_l = 1'b1;
            state_next = S_X3;
          end
        end
      end
      S_X3: begin
        cmd.x_start = 1'b1;
        cmd.x_op    = fps_pkg::XOP_NR_RP;
        state_next  = S_W3;
      end
      S_W3: begin
        if (sts.x_done) state_next = sts.x_pos ? S_NEXT : S_X4;
      end
      S_X4: begin
        cmd.x_start = 1'b1;
        cmd.x_op    = fps_pkg::XOP_NR_LP;
        state_next  = S_W4;
      end
      S_W4: begin
        if (sts.x_done) begin
          if (sts.x_neg) begin
            cmd.restart_l = 1'b1;
            state_next    = S_EMIT;
          end else begin
            cmd.take_r = 1'b1;
            state_next = S_NEXT;
          end
        end
      end
      S_NEXT: begin
        cmd.i_inc  = 1'b1;
        state_next = S_LOOP;
      end
      S_FIN: state_next = sts.goal_differs ? S_GEMIT : S_FLUSH;
      S_GEMIT: begin
        if (sts.emit_ok) begin
          cmd.emit_goal = 1'b1;
          state_next    = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (sts.out_free) begin
          cmd.flush   = 1'b1;
          cmd.clr_req = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int MAXP = 64;
  localparam int WATCHDOG = 200000;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        ovf;
    logic        last;
  } path_pt_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [319:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [95:0] m_tdata;
  logic m_tuser;
  logic m_tlast;

  funnel_path_smoother dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  vec_t lstore[MAXP];
  vec_t rstore[MAXP];
  int unsigned n_portals;
  bit ovf_seen;
  path_pt_t path_q[$];
  int errors = 0;
  int items_sent = 0;
  int points_seen = 0;
  int paths_seen = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int stall_mode = 0;

  function automatic int xsign(longint ux, longint uz, longint vx, longint vz);
    logic signed [127:0] d;
    d = 128'(signed'(ux)) * 128'(signed'(vz)) - 128'(signed'(uz)) * 128'(signed'(vx));
    if (d > 0) return 1;
    if (d < 0) return -1;
    return 0;
  endfunction

  function automatic int rel(vec_t p, vec_t q, vec_t c);
    return xsign(longint'(p.x) - c.x, longint'(p.z) - c.z,
                 longint'(q.x) - c.x, longint'(q.z) - c.z);
  endfunction

  task automatic push_point(vec_t p);
    path_pt_t e;
    e.x = p.x; e.y = p.y; e.z = p.z; e.ovf = ovf_seen; e.last = 0;
    path_q.insert(path_q.size(), e);
  endtask

  task automatic pull_string(vec_t goal);
    int unsigned total, i, apex, li, ri;
    int first;
    vec_t cur, lp, rp, nl, nr;
    total = n_portals + 2;
    first = path_q.size();
    cur = lstore[0]; lp = cur; rp = cur;
    apex = 0; li = 0; ri = 0;
    push_point(cur);
    i = 1;
    while (i < total) begin
      nl = lstore[i]; nr = rstore[i];
      if (rel(nl, lp, cur) >= 0) begin
        if (rel(nl, rp, cur) > 0) begin
          cur = rp; apex = ri; push_point(cur);
          lp = cur; rp = cur; li = apex; ri = apex; i = apex + 1;
          continue;
        end
        lp = nl; li = i;
      end
      if (rel(nr, rp, cur) <= 0) begin
        if (rel(nr, lp, cur) < 0) begin
          cur = lp; apex = li; push_point(cur);
          lp = cur; rp = cur; li = apex; ri = apex; i = apex + 1;
          continue;
        end
        rp = nr; ri = i;
      end
      i++;
    end
    if (cur.x != goal.x || cur.y != goal.y || cur.z != goal.z) push_point(goal);
    path_q[path_q.size() - 1].last = 1;
    if (path_q.size() - first > MAXP) $error("predicted path too long");
  endtask

  task automatic predict(fps_pkg::kind_t k, vec_t a, vec_t b, logic signed [31:0] fx,
                         logic signed [31:0] fz, logic signed [31:0] tx,
                         logic signed [31:0] tz);
    bit keep;
    case (k)
      fps_pkg::KIND_START: begin
        lstore[0] = a; rstore[0] = a; n_portals = 0; ovf_seen = 0;
      end
      fps_pkg::KIND_EDGE: begin
        if (n_portals < MAXP - 2) begin
          keep = xsign(longint'(b.x) - a.x, longint'(b.z) - a.z,
                       longint'(tx) - fx, longint'(tz) - fz) > 0;
          lstore[n_portals + 1] = keep ? a : b;
          rstore[n_portals + 1] = keep ? b : a;
          n_portals++;
        end else begin
          ovf_seen = 1;
        end
      end
      fps_pkg::KIND_GOAL: begin
        if (n_portals > 0) begin
          lstore[n_portals + 1] = a; rstore[n_portals + 1] = a;
          pull_string(a);
        end
        n_portals = 0; ovf_seen = 0;
      end
      default: ;
    endcase
  endtask

  task automatic send(fps_pkg::kind_t k, vec_t a, vec_t b, logic signed [31:0] fx,
                      logic signed [31:0] fz, logic signed [31:0] tx,
                      logic signed [31:0] tz);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        s_tvalid <= 0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1;
    s_tuser <= k;
    s_tdata <= {tz, tx, fz, fx, b.z, b.y, b.x, a.z, a.y, a.x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict(k, a, b, fx, fz, tx, tz);
    items_sent++;
  endtask

  function automatic vec_t rvec(int span);
    vec_t v;
    if (span == 0) begin
      v.x = $urandom; v.y = $urandom; v.z = $urandom;
    end else begin
      v.x = $urandom_range(0, 2 * span) - span;
      v.y = $urandom_range(0, 2 * span) - span;
      v.z = $urandom_range(0, 2 * span) - span;
    end
    return v;
  endfunction

  function automatic vec_t mk(int x, int y, int z);
    vec_t v;
    v.x = x; v.y = y; v.z = z;
    return v;
  endfunction

  // corridor along +z, edges crossing x at width 2*w
  task automatic corridor(int steps, int span, bit flip);
    vec_t a, b, p;
    int z, w;
    p = rvec(span);
    send(fps_pkg::KIND_START, p, rvec(span), 0, 0, 0, 0);
    z = p.z;
    for (int i = 0; i < steps; i++) begin
      z += $urandom_range(1, span / 4 + 1);
      w = $urandom_range(1, span / 2 + 1);
      a = mk(p.x + $urandom_range(0, 2 * w) - w - w, $urandom_range(0, span), z);
      b = mk(a.x + 2 * w, $urandom_range(0, span), z + $urandom_range(0, 3) - 1);
      if (flip && $urandom_range(0, 1)) send(fps_pkg::KIND_EDGE, b, a, p.x, z - 5, p.x, z + 5);
      else send(fps_pkg::KIND_EDGE, a, b, p.x, z - 5, p.x, z + 5);
    end
    send(fps_pkg::KIND_GOAL, mk(p.x + $urandom_range(0, span) - span / 2, p.y, z + 10),
         rvec(0), 0, 0, 0, 0);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (path_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic test_extremes();
    vec_t mn, mx;
    mn = mk(32'h80000000, 32'h80000000, 32'h80000000);
    mx = mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send(fps_pkg::KIND_START, mn, mx, 0, 0, 0, 0);
    send(fps_pkg::KIND_EDGE, mn, mx, 32'h80000000, 32'h80000000, 32'h7fffffff,
         32'h7fffffff);
    send(fps_pkg::KIND_EDGE, mx, mn, 32'h7fffffff, 32'h80000000, 32'h80000000,
         32'h7fffffff);
    send(fps_pkg::KIND_EDGE, mx, mx, 5, 5, 5, 5);
    send(fps_pkg::KIND_NONE, mx, mn, -1, -1, -1, -1);
    send(fps_pkg::KIND_GOAL, mx, mn, 0, 0, 0, 0);
    drain();
  endtask

  task automatic test_no_portal();
    send(fps_pkg::KIND_START, mk(1, 2, 3), mk(0, 0, 0), 0, 0, 0, 0);
    send(fps_pkg::KIND_GOAL, mk(4, 5, 6), mk(0, 0, 0), 0, 0, 0, 0);
    drain();
  endtask

  task automatic test_goal_equal();
    send(fps_pkg::KIND_START, mk(0, 0, 0), mk(0, 0, 0), 0, 0, 0, 0);
    send(fps_pkg::KIND_EDGE, mk(-10, 0, 5), mk(10, 0, 5), 0, 0, 0, 10);
    send(fps_pkg::KIND_GOAL, mk(0, 0, 0), mk(0, 0, 0), 0, 0, 0, 0);
    send(fps_pkg::KIND_START, mk(0, 0, 0), mk(0, 0, 0), 0, 0, 0, 0);
    send(fps_pkg::KIND_EDGE, mk(-10, 0, 5), mk(10, 0, 5), 0, 0, 0, 10);
    send(fps_pkg::KIND_GOAL, mk(0, 1, 0), mk(0, 0, 0), 0, 0, 0, 0);
    drain();
  endtask

  task automatic test_overflow();
    corridor(MAXP, 1000, 1);
    drain();
  endtask

  task automatic test_random();
    int pick;
    while (items_sent < 430) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) corridor($urandom_range(1, 8), 1 << $urandom_range(4, 20), 1);
      else if (pick == 7) corridor($urandom_range(1, 4), 0, 0);
      else if (pick == 8) begin
        send(fps_pkg::KIND_START, rvec(0), rvec(0), $urandom, $urandom, $urandom,
             $urandom);
        repeat ($urandom_range(0, 3))
          send(fps_pkg::kind_t'($urandom_range(1, 3)), rvec(0), rvec(0),
               $urandom, $urandom, $urandom, $urandom);
        send(fps_pkg::KIND_GOAL, rvec(0), rvec(0), $urandom, $urandom, $urandom,
             $urandom);
      end else corridor($urandom_range(20, 40), 5000, 1);
    end
    drain();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: m_tready <= 1;
        1: m_tready <= $urandom_range(0, 1);
        2: m_tready <= ($urandom_range(0, 7) != 0);
        default: m_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    path_pt_t e;
    if (!rst && m_tvalid && m_tready) begin
      points_seen++;
      if (m_tlast) paths_seen++;
      if (path_q.size() == 0) begin
        $error("unexpected path point %h", m_tdata);
        errors++;
      end else begin
        e = path_q.pop_front();
        if (m_tdata[31:0] !== e.x) begin
          $error("point_x expected %h got %h", e.x, m_tdata[31:0]); errors++;
        end
        if (m_tdata[63:32] !== e.y) begin
          $error("point_y expected %h got %h", e.y, m_tdata[63:32]); errors++;
        end
        if (m_tdata[95:64] !== e.z) begin
          $error("point_z expected %h got %h", e.z, m_tdata[95:64]); errors++;
        end
        if (m_tuser !== e.ovf) begin
          $error("overflow expected %b got %b", e.ovf, m_tuser); errors++;
        end
        if (m_tlast !== e.last) begin
          $error("last expected %b got %b", e.last, m_tlast); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    n_portals = 0;
    ovf_seen = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_extremes();
    test_no_portal();
    test_goal_equal();
    test_overflow();
    test_random();
    if (path_q.size() != 0) begin
      $error("%0d path points never arrived", path_q.size());
      errors++;
    end
    $display("covered %0d items, %0d paths, %0d points", items_sent, paths_seen,
             points_seen);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
